FILE: rtl/ldmi_pkg.sv
package ldmi_pkg;

  // File offset counter width
  localparam int OFFSET_WIDTH = 32;

  // Decoupling queue between the parser and the output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes on the configuration port
  localparam logic REG_DATA_TYPE_CODE = 1'b0;
  localparam logic REG_INDEX_INTERVAL = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0]  DATA_TYPE_RESET      = 8'd68;
  localparam logic [31:0] INDEX_INTERVAL_RESET = 32'd1000000;

  // Result kinds
  localparam logic [1:0] KIND_DESC    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // File header and message header geometry
  localparam logic [15:0] FILE_HDR_LEN  = 16'd16;
  localparam logic [15:0] MAGIC_LEN     = 16'd7;
  localparam logic [15:0] DATA_HEAD_LEN = 16'd10;
  localparam logic [15:0] ID_LEN        = 16'd2;

  // File magic
  localparam logic [7:0] MAGIC [7] = '{8'h55, 8'h4C, 8'h6F, 8'h67, 8'h01, 8'h12, 8'h35};

  // One event from the parser to the output stage
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] message_id;
    logic [63:0] stamp;
    logic [31:0] header_offset;
    logic [7:0]  payload_byte;
    logic        last;
  } ldmi_event_t;

  // One finished result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] message_id;
    logic [63:0] stamp;
    logic [31:0] header_offset;
    logic        index_entry;
    logic [7:0]  payload_byte;
    logic        last;
  } ldmi_result_t;

endpackage

FILE: rtl/ldmi_front.sv
module ldmi_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          data_type_code,
  output logic                evt_push,
  output ldmi_pkg::ldmi_event_t evt
);
  import ldmi_pkg::*;

  localparam logic [2:0] PH_FILE_HDR  = 3'd0;
  localparam logic [2:0] PH_MSG_HDR   = 3'd1;
  localparam logic [2:0] PH_SKIP      = 3'd2;
  localparam logic [2:0] PH_DATA_HEAD = 3'd3;
  localparam logic [2:0] PH_PAYLOAD   = 3'd4;
  localparam logic [2:0] PH_DEAD      = 3'd5;

  logic [2:0]              phase, phase_next;
  logic [15:0]             byte_count, byte_count_next;
  logic [15:0]             message_size, message_size_next;
  logic [15:0]             id_shift, id_shift_next;
  logic [63:0]             stamp_shift, stamp_shift_next;
  logic [OFFSET_WIDTH-1:0] file_position, file_position_next;
  logic [OFFSET_WIDTH-1:0] message_start, message_start_next;
  logic [15:0]             count_inc;
  logic [2:0]              lane;
  logic                    evt_valid;

  assign count_inc = byte_count + 16'd1;
  assign lane      = 3'(byte_count - ID_LEN);

  // Parse one byte
  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    message_size_next  = message_size;
    id_shift_next      = id_shift;
    stamp_shift_next   = stamp_shift;
    message_start_next = message_start;
    file_position_next = file_position;
    evt_valid          = 1'b0;
    evt                = '0;

    if (phase != PH_DEAD) begin
      file_position_next = file_position + OFFSET_WIDTH'(1);
    end

    case (phase)
      PH_FILE_HDR: begin
        if (byte_count < MAGIC_LEN && data_byte != MAGIC[byte_count[2:0]]) begin
          phase_next = PH_DEAD;
          evt_valid  = 1'b1;
          evt.kind   = KIND_ERROR;
          evt.last   = 1'b1;
        end else if (count_inc >= FILE_HDR_LEN) begin
          phase_next      = PH_MSG_HDR;
          byte_count_next = '0;
        end else begin
          byte_count_next = count_inc;
        end
      end
      PH_MSG_HDR: begin
        if (byte_count == 16'd0) begin
          message_start_next = file_position;
          message_size_next  = {8'd0, data_byte};
          byte_count_next    = 16'd1;
        end else if (byte_count == 16'd1) begin
          message_size_next[15:8] = data_byte;
          byte_count_next         = 16'd2;
        end else begin
          byte_count_next  = '0;
          id_shift_next    = '0;
          stamp_shift_next = '0;
          if (data_byte == data_type_code && message_size >= DATA_HEAD_LEN) begin
            phase_next = PH_DATA_HEAD;
          end else if (message_size == 16'd0) begin
            phase_next = PH_MSG_HDR;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (count_inc >= message_size) begin
          phase_next      = PH_MSG_HDR;
          byte_count_next = '0;
        end else begin
          byte_count_next = count_inc;
        end
      end
      PH_DATA_HEAD: begin
        // id in the first two bytes, then the little-endian timestamp
        if (byte_count < ID_LEN) begin
          id_shift_next[8*byte_count[0] +: 8] = data_byte;
        end else begin
          stamp_shift_next[8*lane +: 8] = data_byte;
        end
        byte_count_next = count_inc;
        if (count_inc == DATA_HEAD_LEN) begin
          evt_valid         = 1'b1;
          evt.kind          = KIND_DESC;
          evt.message_id    = id_shift_next;
          evt.stamp         = stamp_shift_next;
          evt.header_offset = 32'(message_start);
          evt.last          = (message_size == DATA_HEAD_LEN);
          if (message_size == DATA_HEAD_LEN) begin
            phase_next      = PH_MSG_HDR;
            byte_count_next = '0;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        evt_valid        = 1'b1;
        evt.kind         = KIND_PAYLOAD;
        evt.payload_byte = data_byte;
        byte_count_next  = count_inc;
        if (count_inc >= message_size) begin
          evt.last        = 1'b1;
          phase_next      = PH_MSG_HDR;
          byte_count_next = '0;
        end
      end
      PH_DEAD: begin
        phase_next = PH_DEAD;
      end
      default: begin
        phase_next = PH_DEAD;
      end
    endcase
  end

  assign evt_push = accept && evt_valid;

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FILE_HDR;
      byte_count    <= '0;
      message_size  <= '0;
      id_shift      <= '0;
      stamp_shift   <= '0;
      file_position <= '0;
      message_start <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      message_size  <= message_size_next;
      id_shift      <= id_shift_next;
      stamp_shift   <= stamp_shift_next;
      file_position <= file_position_next;
      message_start <= message_start_next;
    end
  end

`ifndef SYNTHESIS
  a_dead_silent: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DEAD |-> !evt_push)
    else $error("event pushed after bad magic");
  a_error_once: assert property (@(posedge clk) disable iff (rst)
    evt_push && evt.kind == KIND_ERROR |=> phase == PH_DEAD)
    else $error("error beat did not stop the parser");
`endif

endmodule

FILE: rtl/ldmi_queue.sv
module ldmi_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  ldmi_pkg::ldmi_event_t wr_data,
  output logic                  full,
  input  logic                  rd_en,
  output logic                  rd_valid,
  output ldmi_pkg::ldmi_event_t rd_data
);
  import ldmi_pkg::*;

  ldmi_event_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_ptr_level: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with fill level");
`endif

endmodule

FILE: rtl/ldmi_back.sv
module ldmi_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            index_interval,
  input  logic                   evt_valid,
  input  ldmi_pkg::ldmi_event_t  evt,
  output logic                   evt_take,
  input  logic                   pop,
  output logic                   empty,
  output ldmi_pkg::ldmi_result_t res
);
  import ldmi_pkg::*;

  logic        res_valid;
  logic [63:0] index_mark;
  logic        seen_first;
  logic [64:0] limit;
  logic        is_desc;
  logic        idx;

  // Index rule: first descriptor, or stamp reaches last index plus interval
  assign limit   = {1'b0, index_mark} + 65'(index_interval);
  assign is_desc = (evt.kind == KIND_DESC);
  assign idx     = is_desc && (!seen_first || (!limit[64] && evt.stamp >= limit[63:0]));

  assign empty    = !res_valid;
  assign evt_take = evt_valid && (!res_valid || pop);

  // Output register
  always_ff @(posedge clk) begin
    if (evt_take) begin
      res.kind          <= evt.kind;
      res.message_id    <= evt.message_id;
      res.stamp         <= evt.stamp;
      res.header_offset <= evt.header_offset;
      res.index_entry   <= idx;
      res.payload_byte  <= evt.payload_byte;
      res.last          <= evt.last;
    end
  end

  // Output valid and index tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      index_mark <= '0;
      seen_first <= 1'b0;
    end else begin
      if (evt_take) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
      if (evt_take && idx) begin
        index_mark <= evt.stamp;
        seen_first <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_index_desc_only: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind != KIND_DESC |-> !res.index_entry)
    else $error("index flag on a non-descriptor beat");
  a_index_tracks: assert property (@(posedge clk) disable iff (rst)
    evt_take && idx |=> seen_first && index_mark == res.stamp && res.index_entry)
    else $error("index state not updated");
`endif

endmodule

FILE: rtl/log_data_message_indexer_core.sv
// Log data message indexer. Bytes of a log file enter on push/full, one byte
// per cycle at full rate; the 16-byte file header is checked against the
// 7-byte magic, then messages are framed. Each data message of at least ten
// bytes yields one descriptor beat (id, timestamp, header offset, index flag)
// followed by one beat per remaining payload byte, the last one flagged.
// A bad magic gives a single error beat, after which all bytes are dropped
// until reset. Results leave on empty/pop. A byte that produces a result
// passes through a 4-entry queue and then the output register; the queue
// between the parser and the output register absorbs stalls, and full rises
// only when that queue is full, so one byte per cycle is sustained as long
// as pop keeps up. Write configuration only while the block is idle.
module log_data_message_indexer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [15:0] message_id,
  output logic [63:0] stamp,
  output logic [31:0] header_offset,
  output logic        index_entry,
  output logic [7:0]  payload_byte,
  output logic        last,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import ldmi_pkg::*;

  logic [7:0]   data_type_code;
  logic [31:0]  index_interval;
  logic         accept;
  logic         evt_push;
  ldmi_event_t  evt_in;
  ldmi_event_t  evt_out;
  logic         evt_valid;
  logic         evt_take;
  ldmi_result_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      data_type_code <= DATA_TYPE_RESET;
      index_interval <= INDEX_INTERVAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DATA_TYPE_CODE: data_type_code <= cfg_data[7:0];
        REG_INDEX_INTERVAL: index_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  ldmi_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (data_byte),
    .data_type_code (data_type_code),
    .evt_push       (evt_push),
    .evt            (evt_in)
  );

  ldmi_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (evt_push),
    .wr_data  (evt_in),
    .full     (full),
    .rd_en    (evt_take),
    .rd_valid (evt_valid),
    .rd_data  (evt_out)
  );

  ldmi_back u_back (
    .clk            (clk),
    .rst            (rst),
    .index_interval (index_interval),
    .evt_valid      (evt_valid),
    .evt            (evt_out),
    .evt_take       (evt_take),
    .pop            (pop),
    .empty          (empty),
    .res            (res)
  );

  assign kind          = res.kind;
  assign message_id    = res.message_id;
  assign stamp         = res.stamp;
  assign header_offset = res.header_offset;
  assign index_entry   = res.index_entry;
  assign payload_byte  = res.payload_byte;
  assign last          = res.last;

endmodule

FILE: tb/sv/log_data_message_indexer_core_test.sv
module log_data_message_indexer_core_test;
  import ldmi_pkg::*;

  // Run shape
  localparam int RANDOM_BYTES  = 960;
  localparam int TOTAL_BYTES   = 1550;
  localparam int NUM_SETTINGS  = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 100;
  localparam int STALL_LIMIT   = 1000;
  localparam int MAX_PRINTED   = 60;

  // Parser position inside the file
  typedef enum logic [2:0] {
    SCAN_FILE_HEADER,
    SCAN_MSG_HEADER,
    SCAN_SKIP,
    SCAN_DATA_HEAD,
    SCAN_PAYLOAD,
    SCAN_HALTED
  } scan_state_e;

  // Tracks the framing of the byte stream and holds the beats it implies
  class framing_tracker;
    logic [7:0]   type_code;
    logic [31:0]  interval_us;
    scan_state_e  scan_state;
    logic [15:0]  byte_count;
    logic [15:0]  frame_size;
    logic [15:0]  msg_id;
    logic [63:0]  msg_stamp;
    logic [63:0]  last_index_stamp;
    logic         indexed_once;
    logic [31:0]  file_pos;
    logic [31:0]  msg_start;
    ldmi_result_t due_beats[$];
    int           mismatches;
    int           checked;

    function new();
      type_code        = DATA_TYPE_RESET;
      interval_us      = INDEX_INTERVAL_RESET;
      scan_state       = SCAN_FILE_HEADER;
      byte_count       = '0;
      frame_size       = '0;
      msg_id           = '0;
      msg_stamp        = '0;
      last_index_stamp = '0;
      indexed_once     = 1'b0;
      file_pos         = '0;
      msg_start        = '0;
      mismatches       = 0;
      checked          = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == REG_DATA_TYPE_CODE) begin
        type_code = value[7:0];
      end else begin
        interval_us = value;
      end
    endfunction

    function int pending();
      return due_beats.size();
    endfunction

    // Advance the framing by one accepted byte
    function void take_byte(logic [7:0] b);
      ldmi_result_t beat;
      logic [31:0]  pos;
      logic [64:0]  limit;
      logic         idx;
      if (scan_state == SCAN_HALTED) return;
      pos      = file_pos;
      file_pos = file_pos + 32'd1;
      beat     = '0;
      case (scan_state)
        SCAN_FILE_HEADER: begin
          if (byte_count < MAGIC_LEN && b != MAGIC[byte_count]) begin
            scan_state = SCAN_HALTED;
            beat.kind  = KIND_ERROR;
            beat.last  = 1'b1;
            due_beats.push_back(beat);
          end else begin
            byte_count += 16'd1;
            if (byte_count >= FILE_HDR_LEN) begin
              scan_state = SCAN_MSG_HEADER;
              byte_count = '0;
            end
          end
        end
        SCAN_MSG_HEADER: begin
          if (byte_count == 16'd0) begin
            msg_start  = pos;
            frame_size = {8'h00, b};
            byte_count = 16'd1;
          end else if (byte_count == 16'd1) begin
            frame_size[15:8] = b;
            byte_count       = 16'd2;
          end else begin
            byte_count = '0;
            msg_id     = '0;
            msg_stamp  = '0;
            if (b == type_code && frame_size >= DATA_HEAD_LEN) begin
              scan_state = SCAN_DATA_HEAD;
            end else if (frame_size != 16'd0) begin
              scan_state = SCAN_SKIP;
            end
          end
        end
        SCAN_SKIP: begin
          byte_count += 16'd1;
          if (byte_count >= frame_size) begin
            scan_state = SCAN_MSG_HEADER;
            byte_count = '0;
          end
        end
        SCAN_DATA_HEAD: begin
          if (byte_count < ID_LEN) begin
            msg_id[8*byte_count +: 8] = b;
          end else begin
            msg_stamp[8*(byte_count - ID_LEN) +: 8] = b;
          end
          byte_count += 16'd1;
          if (byte_count == DATA_HEAD_LEN) begin
            // index rule: first one, or far enough past the last entry without carry
            limit = {1'b0, last_index_stamp} + {33'd0, interval_us};
            idx   = !indexed_once || (!limit[64] && msg_stamp >= limit[63:0]);
            if (idx) begin
              last_index_stamp = msg_stamp;
              indexed_once     = 1'b1;
            end
            beat.kind          = KIND_DESC;
            beat.message_id    = msg_id;
            beat.stamp         = msg_stamp;
            beat.header_offset = msg_start;
            beat.index_entry   = idx;
            beat.last          = (frame_size == DATA_HEAD_LEN);
            due_beats.push_back(beat);
            if (frame_size == DATA_HEAD_LEN) begin
              scan_state = SCAN_MSG_HEADER;
              byte_count = '0;
            end else begin
              scan_state = SCAN_PAYLOAD;
            end
          end
        end
        SCAN_PAYLOAD: begin
          byte_count += 16'd1;
          beat.kind         = KIND_PAYLOAD;
          beat.payload_byte = b;
          if (byte_count >= frame_size) begin
            beat.last  = 1'b1;
            scan_state = SCAN_MSG_HEADER;
            byte_count = '0;
          end
          due_beats.push_back(beat);
        end
        default: scan_state = SCAN_HALTED;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("MISMATCH: %s", msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("beat %0d: %s is %0h, expected %0h",
                                  checked, name, got, want));
      end
    endtask

    // Compare one accepted result beat against the oldest due beat
    task check_beat(ldmi_result_t got);
      ldmi_result_t want;
      if (due_beats.size() == 0) begin
        report_mismatch($sformatf("beat %0d of kind %0d arrived with none due",
                                  checked, got.kind));
      end else begin
        want = due_beats.pop_front();
        compare_field("kind", got.kind, want.kind);
        compare_field("message_id", got.message_id, want.message_id);
        compare_field("stamp", got.stamp, want.stamp);
        compare_field("header_offset", got.header_offset, want.header_offset);
        compare_field("index_entry", got.index_entry, want.index_entry);
        compare_field("payload_byte", got.payload_byte, want.payload_byte);
        compare_field("last", got.last, want.last);
      end
      checked++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        empty;
  logic        pop;
  logic [1:0]  kind;
  logic [15:0] message_id;
  logic [63:0] stamp;
  logic [31:0] header_offset;
  logic        index_entry;
  logic [7:0]  payload_byte;
  logic        last;
  logic        cfg_write;
  logic        cfg_index;
  logic [31:0] cfg_data;

  framing_tracker tracker = new();

  logic        hold_pending;
  logic        sender_steady;
  logic [63:0] stamp_clock;
  int          bytes_sent;

  log_data_message_indexer_core dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .empty        (empty),
    .pop          (pop),
    .kind         (kind),
    .message_id   (message_id),
    .stamp        (stamp),
    .header_offset(header_offset),
    .index_entry  (index_entry),
    .payload_byte (payload_byte),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Timestamps mostly march forward in steps around the interval
  function automatic logic [63:0] next_stamp(input logic [31:0] interval);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      stamp_clock = stamp_clock + (64'(interval) * $urandom_range(0, 20)) / 10
                    + $urandom_range(0, 2);
    end else if (pick < 72) begin
      stamp_clock = stamp_clock - $urandom_range(0, 1000);
    end else if (pick < 85) begin
      stamp_clock = {$urandom, $urandom};
    end else if (pick < 95) begin
      stamp_clock = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 5000);
    end else begin
      stamp_clock = '0;
    end
    return stamp_clock;
  endfunction

  // One byte beat on the input side; returns right after acceptance
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push      <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_message(input logic [15:0] size, input logic [7:0] mtype,
                              input logic [15:0] id, input logic [63:0] ts);
    logic [7:0] b;
    send_byte(size[7:0]);
    send_byte(size[15:8]);
    send_byte(mtype);
    for (int i = 0; i < size; i++) begin
      if (i < 2) b = id[8*i +: 8];
      else if (i < 10) b = ts[8*(i-2) +: 8];
      else b = 8'($urandom);
      send_byte(b);
    end
  endtask

  task automatic send_random_message(input logic [7:0] code, input logic [31:0] interval);
    int          pick;
    logic [15:0] size;
    logic [7:0]  mtype;
    pick  = $urandom_range(0, 99);
    mtype = code;
    if (pick < 15) size = 16'd10;
    else if (pick < 65) size = 16'($urandom_range(11, 30));
    else if (pick < 70) size = 16'($urandom_range(31, 200));
    else if (pick < 80) size = 16'($urandom_range(0, 9));
    else begin
      // foreign or junk message, type may collide with the data code
      mtype = 8'($urandom);
      size  = 16'($urandom_range(0, 24));
    end
    sender_steady = ($urandom_range(0, 4) == 0);
    send_message(size, mtype, 16'($urandom), next_stamp(interval));
  endtask

  // Stop sending and let the block run dry
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    tracker.set_register(idx, value);
  endtask

  // Result side: random pop gaps, steady stretches, one long hold-off
  initial begin : result_sink
    int           gap;
    int           steady_left;
    ldmi_result_t got;
    steady_left = 0;
    wait (rst == 1'b0);
    forever begin
      if (hold_pending) begin
        gap          = HOLD_CYCLES;
        hold_pending = 1'b0;
      end else if (steady_left > 0) begin
        gap = 0;
        steady_left--;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 7) == 0) steady_left = $urandom_range(16, 96);
      end
      if (gap > 0) begin
        @(negedge clk);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got.kind          = kind;
      got.message_id    = message_id;
      got.stamp         = stamp;
      got.header_offset = header_offset;
      got.index_entry   = index_entry;
      got.payload_byte  = payload_byte;
      got.last          = last;
      tracker.check_beat(got);
    end
  end

  // Ends the run when no beat moves on either side for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle = 0;
      else idle++;
    end
    tracker.report_mismatch($sformatf("no beat moved for %0d cycles, %0d still due",
                                      STALL_LIMIT, tracker.pending()));
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  code;
    logic [31:0] interval;
    logic        bad_run;
    int          bad_pos;
    int          budget_end;
    rst           = 1'b1;
    push          = 1'b0;
    data_byte     = '0;
    pop           = 1'b0;
    cfg_write     = 1'b0;
    cfg_index     = REG_DATA_TYPE_CODE;
    cfg_data      = '0;
    hold_pending  = 1'b0;
    sender_steady = 1'b0;
    stamp_clock   = '0;
    bytes_sent    = 0;
    code          = DATA_TYPE_RESET;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // A bad magic halts the block for good, so only some runs take that path
    bad_run = ($urandom_range(0, 9) == 0);
    if (bad_run) begin
      code = 8'($urandom);
      write_register(REG_DATA_TYPE_CODE, {24'd0, code});
      write_register(REG_INDEX_INTERVAL, $urandom);
      bad_pos = $urandom_range(0, 6);
      for (int i = 0; i < bad_pos; i++) send_byte(MAGIC[i]);
      send_byte(MAGIC[bad_pos] ^ 8'($urandom_range(1, 255)));
      while (bytes_sent < TOTAL_BYTES) send_byte(8'($urandom));
    end else begin
      // file header: magic, then filler that is not checked
      for (int i = 0; i < 16; i++) begin
        if (i < 7) send_byte(MAGIC[i]);
        else send_byte(8'($urandom));
      end
      // reset settings: first entry, just short of and exactly at the interval
      send_message(16'd10, code, 16'h0000, 64'd0);
      send_message(16'd12, code, 16'hFFFF, 64'd999_999);
      send_message(16'd11, code, 16'h1234, 64'd1_000_000);
      // near the top of the range, then a sum that would carry out
      send_message(16'd10, code, 16'h8001, 64'hFFFF_FFFF_FFFF_FF00);
      send_message(16'd10, code, 16'h7FFE, 64'hFFFF_FFFF_FFFF_FFFF);
      // skipped: short data, empty foreign, empty data, short foreign
      send_message(16'd9, code, 16'h5555, 64'd0);
      send_message(16'd0, 8'h46, 16'h0000, 64'd0);
      send_message(16'd0, code, 16'h0000, 64'd0);
      send_message(16'd3, 8'h46, 16'hAAAA, 64'd0);

      for (int p = 0; p < NUM_SETTINGS; p++) begin
        settle();
        case (p)
          0: begin code = 8'h00; interval = 32'd0; end
          1: begin code = 8'hFF; interval = 32'hFFFF_FFFF; end
          2: begin code = DATA_TYPE_RESET; interval = INDEX_INTERVAL_RESET; end
          default: begin
            code = ($urandom_range(0, 3) == 0) ? DATA_TYPE_RESET : 8'($urandom);
            case ($urandom_range(0, 4))
              0: interval = 32'd0;
              1: interval = $urandom_range(1, 5000);
              2: interval = INDEX_INTERVAL_RESET;
              3: interval = 32'hFFFF_FFFF;
              default: interval = $urandom;
            endcase
          end
        endcase
        write_register(REG_DATA_TYPE_CODE, {24'd0, code});
        write_register(REG_INDEX_INTERVAL, interval);
        if (p == 2) begin
          // sink holds off while bytes keep coming, so the input side backs up
          hold_pending  = 1'b1;
          sender_steady = 1'b1;
          send_message(16'd80, code, 16'($urandom), next_stamp(interval));
          sender_steady = 1'b0;
        end
        if (p == 4) begin
          // one message whose size needs both size bytes
          sender_steady = 1'b0;
          send_message(16'd260, code, 16'($urandom), next_stamp(interval));
        end
        budget_end = bytes_sent + RANDOM_BYTES / NUM_SETTINGS;
        while (bytes_sent < budget_end) send_random_message(code, interval);
      end

      // file cut off inside a data message: no descriptor yet
      sender_steady = 1'b0;
      send_byte(8'd20);
      send_byte(8'd0);
      send_byte(code);
      repeat (6) send_byte(8'($urandom));
    end

    @(negedge clk);
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
